>>> hdl/scfp_pkg.sv
package scfp_pkg;

    // guard bits carried on the datapath above the input width
    localparam int GUARD_BITS = 2;

endpackage

>>> hdl/scfp_divider.sv
// restoring divider, one quotient bit per cycle
module scfp_divider #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    shifted;
    logic [W:0]    diff;

    assign shifted = {rem_reg[W-1:0], quo_reg[W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    // one restoring step per cycle
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

>>> hdl/scfp_isqrt.sv
// bitwise integer square root, one result bit per cycle
module scfp_isqrt #(
    parameter int W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         value,
    output logic                 done,
    output logic [(W+1)/2-1:0]   root,
    output logic                 exact
);
    localparam int RW = (W + 1) / 2;
    localparam int VW = 2 * RW;
    localparam int CW = $clog2(RW + 1);

    logic [VW-1:0] val_reg, val_next;
    logic [RW+1:0] rem_reg, rem_next;
    logic [RW-1:0] res_reg, res_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW+1:0] trial;
    logic [RW+1:0] diff;

    assign trial = {rem_reg[RW-1:0], val_reg[VW-1 -: 2]};
    assign diff  = trial - {res_reg, 2'b01};

    // two input bits shifted in per step
    always_comb
    begin
        val_next  = val_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            val_next  = VW'(value);
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[VW-3:0], 2'b00};
            if (!diff[RW+1])
            begin
                rem_next = diff;
                res_next = {res_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                res_next = {res_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done  = done_reg;
    assign root  = res_reg;
    assign exact = (rem_reg == '0);
endmodule

>>> hdl/sqrt_continued_fraction_period.sv
// continued-fraction period of the square root of n
// input channel: n on in_valid/in_ready; one result word per input word on
// out_valid/out_ready carrying root, period and the three flags
// one word is expanded at a time: in_ready is high only while idle
// the root comes from the bitwise square root unit after the word is accepted
// each period term then runs a*q and p*p on a shift-add multiplier and q
// and a on a restoring divider
// a perfect square goes straight to the result; otherwise the terms follow,
// up to 2^PERIOD_WIDTH - 1 terms when saturated
// the next word is accepted the cycle after the result is registered
// a finished result waits in the output register while out_ready is low;
// the next word is expanded meanwhile but cannot be handed off, so the
// input stalls until the register is free
// reset returns the block to idle with no result pending
module sqrt_continued_fraction_period #(
    parameter int N_WIDTH      = 16,
    parameter int PERIOD_WIDTH = 12
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [N_WIDTH-1:0]         n,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [(N_WIDTH+1)/2-1:0]   root,
    output logic [PERIOD_WIDTH-1:0]    period,
    output logic                       odd_period,
    output logic                       is_square,
    output logic                       period_overflow
);
    import scfp_pkg::*;

    localparam int RW = (N_WIDTH + 1) / 2;
    localparam int DW = N_WIDTH + GUARD_BITS;
    localparam logic [PERIOD_WIDTH-1:0] LIMIT = '1;

    // iteration phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SQRT,
        PH_MULAQ,
        PH_MULPP,
        PH_DIVQ,
        PH_DIVA,
        PH_DONE
    } phase_t;

    phase_t                  ph_reg, ph_next;
    logic [N_WIDTH-1:0]      n_reg, n_next;
    logic [DW-1:0]           r_reg, r_next;
    logic [DW-1:0]           a_reg, a_next;
    logic [DW-1:0]           p_reg, p_next;
    logic [DW-1:0]           q_reg, q_next;
    logic [DW-1:0]           t_reg, t_next;
    logic [DW-1:0]           acc_reg, acc_next;
    logic [DW-1:0]           mc_reg, mc_next;
    logic [DW-1:0]           mp_reg, mp_next;
    logic [PERIOD_WIDTH-1:0] cnt_reg, cnt_next;
    logic                    sq_reg, sq_next;
    logic                    ovf_reg, ovf_next;
    logic                    ov_reg, ov_next;
    logic                    out_valid_reg, out_valid_next;
    logic [RW-1:0]           root_reg, root_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic                    odd_reg, odd_next;
    logic                    square_reg, square_next;
    logic                    pover_reg, pover_next;

    logic                    sq_start, sq_done, sq_exact;
    logic [RW-1:0]           sq_root;
    logic                    dv_start, dv_done;
    logic [DW-1:0]           dv_dividend, dv_divisor, dv_quo;
    logic [DW-1:0]           p_new;
    logic [DW-1:0]           t_new;

    scfp_isqrt #(.W(N_WIDTH)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sq_start), .value(n),
        .done(sq_done), .root(sq_root), .exact(sq_exact)
    );

    scfp_divider #(.W(DW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_dividend),
        .divisor(dv_divisor), .done(dv_done), .quotient(dv_quo)
    );

    // p' = a*q - p and n - p'^2 from the finished product
    assign p_new = (acc_reg >= p_reg) ? acc_reg - p_reg : '0;
    assign t_new = (DW'(n_reg) >= acc_reg) ? DW'(n_reg) - acc_reg : '0;

    assign in_ready = (ph_reg == PH_IDLE);

    // control sequencer
    always_comb
    begin
        ph_next        = ph_reg;
        n_next         = n_reg;
        r_next         = r_reg;
        a_next         = a_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        t_next         = t_reg;
        acc_next       = acc_reg;
        mc_next        = mc_reg;
        mp_next        = mp_reg;
        cnt_next       = cnt_reg;
        sq_next        = sq_reg;
        ovf_next       = ovf_reg;
        ov_next        = ov_reg;
        out_valid_next = out_valid_reg;
        root_next      = root_reg;
        period_next    = period_reg;
        odd_next       = odd_reg;
        square_next    = square_reg;
        pover_next     = pover_reg;
        sq_start       = 1'b0;
        dv_start       = 1'b0;
        dv_dividend    = t_reg;
        dv_divisor     = q_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (ph_reg)
            PH_IDLE:
            begin
                if (in_valid)
                begin
                    n_next   = n;
                    ph_next  = PH_SQRT;
                    sq_start = 1'b1;
                end
            end
            PH_SQRT:
            begin
                if (sq_done)
                begin
                    r_next   = DW'(sq_root);
                    a_next   = DW'(sq_root);
                    p_next   = '0;
                    q_next   = DW'(1);
                    cnt_next = '0;
                    sq_next  = sq_exact;
                    ovf_next = 1'b0;
                    acc_next = '0;
                    mc_next  = DW'(sq_root);
                    mp_next  = DW'(1);
                    ph_next  = sq_exact ? PH_DONE : PH_MULAQ;
                end
            end
            PH_MULAQ, PH_MULPP:
            begin
                // one multiplier bit per cycle until no set bits remain
                if (mp_reg != '0)
                begin
                    if (mp_reg[0])
                        acc_next = acc_reg + mc_reg;
                    mc_next = {mc_reg[DW-2:0], 1'b0};
                    mp_next = {1'b0, mp_reg[DW-1:1]};
                end
                else if (ph_reg == PH_MULAQ)
                begin
                    p_next   = p_new;
                    acc_next = '0;
                    mc_next  = p_new;
                    mp_next  = p_new;
                    ph_next  = PH_MULPP;
                end
                else
                begin
                    t_next  = t_new;
                    ph_next = PH_DIVQ;
                end
            end
            PH_DIVQ:
            begin
                // first cycle launches q = (n - p^2)/q
                if (!ov_reg)
                begin
                    dv_start = 1'b1;
                    ov_next  = 1'b1;
                end
                else if (dv_done)
                begin
                    ov_next = 1'b0;
                    q_next  = dv_quo;
                    if (dv_quo == '0)
                    begin
                        ovf_next = 1'b1;
                        cnt_next = LIMIT;
                        ph_next  = PH_DONE;
                    end
                    else
                        ph_next = PH_DIVA;
                end
            end
            PH_DIVA:
            begin
                dv_dividend = r_reg + p_reg;
                dv_divisor  = q_reg;
                if (!ov_reg)
                begin
                    dv_start = 1'b1;
                    ov_next  = 1'b1;
                end
                else if (dv_done)
                begin
                    ov_next  = 1'b0;
                    a_next   = dv_quo;
                    cnt_next = cnt_reg + 1'b1;
                    acc_next = '0;
                    mc_next  = dv_quo;
                    mp_next  = q_reg;
                    if (q_reg == DW'(1))
                        ph_next = PH_DONE;
                    else if (cnt_reg + 1'b1 == LIMIT)
                    begin
                        ovf_next = 1'b1;
                        ph_next  = PH_DONE;
                    end
                    else
                        ph_next = PH_MULAQ;
                end
            end
            PH_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    root_next      = r_reg[RW-1:0];
                    period_next    = cnt_reg;
                    odd_next       = !sq_reg && !ovf_reg && cnt_reg[0];
                    square_next    = sq_reg;
                    pover_next     = ovf_reg;
                    ph_next        = PH_IDLE;
                end
            end
            default:
                ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_IDLE;
            n_reg         <= '0;
            r_reg         <= '0;
            a_reg         <= '0;
            p_reg         <= '0;
            q_reg         <= '0;
            t_reg         <= '0;
            acc_reg       <= '0;
            mc_reg        <= '0;
            mp_reg        <= '0;
            cnt_reg       <= '0;
            sq_reg        <= 1'b0;
            ovf_reg       <= 1'b0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            root_reg      <= '0;
            period_reg    <= '0;
            odd_reg       <= 1'b0;
            square_reg    <= 1'b0;
            pover_reg     <= 1'b0;
        end
        else
        begin
            ph_reg        <= ph_next;
            n_reg         <= n_next;
            r_reg         <= r_next;
            a_reg         <= a_next;
            p_reg         <= p_next;
            q_reg         <= q_next;
            t_reg         <= t_next;
            acc_reg       <= acc_next;
            mc_reg        <= mc_next;
            mp_reg        <= mp_next;
            cnt_reg       <= cnt_next;
            sq_reg        <= sq_next;
            ovf_reg       <= ovf_next;
            ov_reg        <= ov_next;
            out_valid_reg <= out_valid_next;
            root_reg      <= root_next;
            period_reg    <= period_next;
            odd_reg       <= odd_next;
            square_reg    <= square_next;
            pover_reg     <= pover_next;
        end
    end

    // result word
    assign out_valid       = out_valid_reg;
    assign root            = root_reg;
    assign period          = period_reg;
    assign odd_period      = odd_reg;
    assign is_square       = square_reg;
    assign period_overflow = pover_reg;
endmodule
